// ===== src/tdt_pkg.sv =====
package tdt_pkg;

    localparam int TIME_W = 48;
    localparam int PER_W  = 32;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [PER_W-1:0]  WINDOW_RESET = 32'd3600000;

    localparam logic [2:0] MODE_ADD     = 3'd0;
    localparam logic [2:0] MODE_CANCEL  = 3'd1;
    localparam logic [2:0] MODE_REFRESH = 3'd2;
    localparam logic [2:0] MODE_RESET   = 3'd3;
    localparam logic [2:0] MODE_QUERY   = 3'd4;
    localparam logic [2:0] MODE_EXPIRE  = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NOP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]        status;
        logic [3:0]        slot_out;
        logic              fired;
        logic [TIME_W-1:0] wait_ms;
        logic              none_pending;
        logic              front_notice;
        logic              rolled_back;
        logic              last;
    } t_result;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // latch the input transaction, clear scan state
        logic scan;       // examine the slot at the scan index
        logic finish;     // apply the single-result operation, build result
        logic pick;       // emit the selected expiry slot, update it
        logic done_exp;   // build the closing expire result with nothing fired
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic scan_end;
        logic is_expire;
        logic exp_found;
        logic exp_last;
    } t_stat;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [PER_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W-PER_W+1){1'b0}}, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

// ===== src/tdt_ctrl.sv =====
module tdt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_free,
    output logic          o_out_push,
    output tdt_pkg::t_cmd o_cmd,
    input  tdt_pkg::t_stat i_stat
);
    import tdt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_out_push = 1'b0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_end) begin
                    n_state = i_stat.is_expire ? S_EMIT : S_IDLE;
                    if (!i_stat.is_expire) begin
                        if (i_out_free) begin
                            o_cmd.scan   = 1'b0;
                            o_cmd.finish = 1'b1;
                            o_out_push   = 1'b1;
                        end else begin
                            n_state = S_SCAN;
                            o_cmd.scan = 1'b0;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_out_push = 1'b1;
                    if (i_stat.exp_found) begin
                        o_cmd.pick = 1'b1;
                        n_state    = i_stat.exp_last ? S_IDLE : S_SCAN;
                    end else begin
                        o_cmd.done_exp = 1'b1;
                        n_state        = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_load_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && o_cmd.pick)) else $error("load with pick");
    a_push_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pick |-> o_out_push) else $error("pick without push");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_push) else $error("push while idle");
    a_load_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_SCAN)) else $error("load not followed by scan");

endmodule

// ===== src/tdt_dp.sv =====
module tdt_dp #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  tdt_pkg::t_cmd            i_cmd,
    output tdt_pkg::t_stat           o_stat,
    input  logic [31:0]              i_window,
    input  logic [2:0]               i_mode,
    input  logic [47:0]              i_now,
    input  logic [3:0]               i_slot,
    input  logic [31:0]              i_period,
    input  logic                     i_repeat,
    input  logic                     i_restart,
    output tdt_pkg::t_result         o_result
);
    import tdt_pkg::*;

    localparam int IW = $clog2(TIMER_SLOTS);
    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam int MAX_OUT = 16;

    logic [TIME_W-1:0] r_deadline [TIMER_SLOTS];
    logic [PER_W-1:0]  r_period   [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] r_rec, r_act, r_fired;
    logic r_notice;
    logic [TIME_W-1:0] r_prev;

    logic [2:0]        r_mode;
    logic [TIME_W-1:0] r_now;
    logic [3:0]        r_slot;
    logic [PER_W-1:0]  r_per;
    logic              r_rep, r_fnow;

    logic [CW-1:0]     r_idx;
    logic              r_best_v;
    logic [IW-1:0]     r_best;
    logic [TIME_W-1:0] r_best_dl;
    logic              r_free_v;
    logic [IW-1:0]     r_free;
    logic              r_any;
    logic              r_roll;
    logic [4:0]        r_nout;
    logic [4:0]        r_ndue;
    t_result           r_result;
    t_result           n_result;

    logic [IW-1:0]     w_i;
    logic              w_elig, w_better, w_in_range, w_act_s, w_front, w_roll;
    logic              w_last_pick;
    logic [IW-1:0]     w_s;
    logic [TIME_W-1:0] w_dl_s, w_start, w_newdl, w_add_dl;
    logic [PER_W-1:0]  w_per_s;
    logic [1:0]        w_st;

    assign w_i = r_idx[IW-1:0];
    assign w_in_range = (32'(r_slot) < 32'(TIMER_SLOTS));
    assign w_s = IW'(r_slot);
    assign w_act_s = w_in_range && r_act[w_s];
    assign w_dl_s  = r_deadline[w_s];
    assign w_per_s = r_period[w_s];
    assign w_roll = (i_now < r_prev) && (r_prev >= {16'd0, i_window})
                    && (i_now < r_prev - {16'd0, i_window});

    always_comb begin
        w_elig = r_act[w_i] && !r_fired[w_i];
        if (r_mode == MODE_EXPIRE) begin
            w_elig = w_elig && (r_roll || r_deadline[w_i] <= r_now);
        end
        w_better = !r_best_v || (r_deadline[w_i] < r_best_dl);
    end

    assign w_add_dl = sat_add(r_now, r_per);
    assign w_front  = (!r_best_v || (w_add_dl < r_best_dl)
                       || (w_add_dl == r_best_dl && r_free < r_best)) && !r_notice;

    assign w_start = r_fnow ? r_now :
                     (w_dl_s >= {16'd0, w_per_s} ? w_dl_s - {16'd0, w_per_s} : '0);
    assign w_newdl = sat_add(w_start, r_per);

    assign w_last_pick = ((r_nout + 5'd1) == r_ndue);

    always_comb begin
        w_st = ST_NOP;
        if (w_act_s) begin
            case (r_mode)
                MODE_CANCEL, MODE_REFRESH: w_st = ST_OK;
                MODE_RESET: w_st = (r_per == w_per_s && !r_fnow) ? ST_NOP : ST_OK;
                default: w_st = ST_NOP;
            endcase
        end
    end

    always_comb begin
        n_result      = '0;
        n_result.last = 1'b1;
        if (i_cmd.pick) begin
            n_result.slot_out    = 4'(r_best);
            n_result.fired       = 1'b1;
            n_result.rolled_back = r_roll;
            n_result.last        = w_last_pick;
        end else if (i_cmd.done_exp) begin
            n_result.rolled_back = r_roll;
        end else begin
            case (r_mode)
                MODE_ADD: begin
                    if (!r_free_v) begin
                        n_result.status = ST_FULL;
                    end else begin
                        n_result.slot_out     = 4'(r_free);
                        n_result.front_notice = w_front;
                    end
                end
                MODE_CANCEL, MODE_REFRESH, MODE_RESET: n_result.status = w_st;
                MODE_QUERY: begin
                    if (!r_best_v) begin
                        n_result.wait_ms      = TIME_MAX;
                        n_result.none_pending = 1'b1;
                    end else begin
                        n_result.wait_ms = (r_now >= r_best_dl) ? '0 : r_best_dl - r_now;
                    end
                end
                MODE_EXPIRE: ;
                default: n_result.status = ST_NOP;
            endcase
        end
    end

    assign o_result = r_result;

    assign o_stat.scan_end  = (r_idx == CW'(TIMER_SLOTS));
    assign o_stat.is_expire = (r_mode == MODE_EXPIRE) && r_any;
    assign o_stat.exp_found = r_best_v;
    assign o_stat.exp_last  = w_last_pick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= '0;
            r_rec    <= '0;
            r_notice <= 1'b0;
            r_prev   <= '0;
            r_idx    <= '0;
            r_mode   <= '0;
            r_best_v <= 1'b0;
            r_free_v <= 1'b0;
            r_ndue   <= '0;
            r_nout   <= '0;
            r_result <= '0;
            for (int k = 0; k < TIMER_SLOTS; k++) begin
                r_deadline[k] <= '0;
                r_period[k]   <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_mode <= i_mode; r_now <= i_now; r_slot <= i_slot; r_per <= i_period;
                r_rep <= i_repeat; r_fnow <= i_restart;
                r_idx <= '0; r_best_v <= 1'b0; r_free_v <= 1'b0; r_free <= '0;
                r_fired <= '0; r_nout <= '0; r_ndue <= '0;
                r_any <= |r_act;
                r_roll <= w_roll;
                if (i_mode == MODE_EXPIRE && |r_act) r_prev <= i_now;
                if (i_mode == MODE_QUERY) r_notice <= 1'b0;
            end
            if (i_cmd.scan && !o_stat.scan_end) begin
                r_idx <= r_idx + 1'b1;
                if (!r_act[w_i] && !r_free_v) begin
                    r_free_v <= 1'b1;
                    r_free   <= w_i;
                end
                if (w_elig && w_better) begin
                    r_best_v  <= 1'b1;
                    r_best    <= w_i;
                    r_best_dl <= r_deadline[w_i];
                end
                if (w_elig && r_nout == '0 && r_ndue != 5'(MAX_OUT)) begin
                    r_ndue <= r_ndue + 1'b1;
                end
            end
            if (i_cmd.finish || i_cmd.pick || i_cmd.done_exp) begin
                r_result <= n_result;
            end
            if (i_cmd.finish) begin
                case (r_mode)
                    MODE_ADD: begin
                        if (r_free_v) begin
                            r_deadline[r_free] <= w_add_dl;
                            r_period[r_free]   <= r_per;
                            r_rec[r_free]      <= r_rep;
                            r_act[r_free]      <= 1'b1;
                            if (w_front) r_notice <= 1'b1;
                        end
                    end
                    MODE_CANCEL, MODE_REFRESH, MODE_RESET: begin
                        if (w_st == ST_OK) begin
                            case (r_mode)
                                MODE_CANCEL: r_act[w_s] <= 1'b0;
                                MODE_REFRESH: r_deadline[w_s] <= sat_add(r_now, w_per_s);
                                default: begin
                                    r_period[w_s]   <= r_per;
                                    r_deadline[w_s] <= w_newdl;
                                end
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.pick) begin
                r_fired[r_best] <= 1'b1;
                if (r_rec[r_best]) r_deadline[r_best] <= sat_add(r_now, r_period[r_best]);
                else r_act[r_best] <= 1'b0;
                r_nout <= r_nout + 1'b1;
                r_idx <= '0;
                r_best_v <= 1'b0;
            end
        end
    end

endmodule

// ===== src/tdt_top_fix.sv =====
module tdt_ostage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_free
);
    logic r_valid;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_free) else $error("push into full output stage");

endmodule

// ===== src/timer_deadline_table_top.sv =====
// Timer deadline table.
// The slave stream carries one operation per transaction: mode, time, slot,
// period and flags. The master stream returns results; tlast marks the final
// result of each operation. Expire returns one result per fired slot, in
// deadline order, at most sixteen, or a single result when nothing fires.
// Each operation scans all TIMER_SLOTS slots, one per cycle. A single-result
// operation builds its result in the output register when the scan ends and
// the output stage is free. Expire repeats the scan for every fired slot,
// emitting one result after each scan.
// The next operation is accepted only after the last result is registered.
// i_rollback_we writes the rollback window; the user must do so only while
// the block is idle, which the block does not enforce. Synchronous reset
// frees all slots, clears the notice and the previous time, and sets the
// window to one hour. When the receiver stalls, the result holds in the
// output register and the next result waits at the end of its scan.
module timer_deadline_table_top #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rollback_we,
    input  logic [31:0] i_rollback_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[2:0], now_ms[50:3], slot_in[54:51], period_ms[86:55],
    // repeat_req[87], restart[88], zero fill to 96 bits
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], slot_out[5:2], fired[6], wait_ms[54:7], none_pending[55],
    // front_notice[56], rolled_back[57], zero fill to 64 bits
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import tdt_pkg::*;

    logic [31:0]    r_window;
    t_cmd           w_cmd;
    t_stat          w_stat;
    t_result        w_res;
    logic           w_push, w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_rollback_we) begin
            r_window <= i_rollback_wdata;
        end
    end

    tdt_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_out_free(w_free), .o_out_push(w_push),
        .o_cmd(w_cmd), .i_stat(w_stat)
    );

    tdt_dp #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_stat(w_stat), .i_window(r_window),
        .i_mode(s_axis_tdata[2:0]), .i_now(s_axis_tdata[50:3]),
        .i_slot(s_axis_tdata[54:51]), .i_period(s_axis_tdata[86:55]),
        .i_repeat(s_axis_tdata[87]), .i_restart(s_axis_tdata[88]),
        .o_result(w_res)
    );

    tdt_ostage u_out (
        .i_clk, .i_rst_n, .i_push(w_push), .i_ready(m_axis_tready),
        .o_valid(m_axis_tvalid), .o_free(w_free)
    );

    assign m_axis_tdata = {6'd0, w_res.rolled_back, w_res.front_notice, w_res.none_pending,
                           w_res.wait_ms, w_res.fired, w_res.slot_out, w_res.status};
    assign m_axis_tlast = w_res.last;

endmodule

// ===== verif/timer_table_checker.sv =====
`timescale 1ns / 100ps

module timer_table_checker #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rollback_we,
    input  logic [31:0] i_rollback_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [95:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,
    input  logic        i_m_tlast,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    import tdt_pkg::*;

    logic [TIME_W-1:0] deadline_q [TIMER_SLOTS];
    logic [PER_W-1:0]  period_q [TIMER_SLOTS];
    logic              recurring_q [TIMER_SLOTS];
    logic              active_q [TIMER_SLOTS];
    logic              notice_q;
    logic [TIME_W-1:0] prev_time_q;
    logic [PER_W-1:0]  window_q;
    t_result           expected_results [$];

    function automatic logic [TIME_W-1:0] add_saturate(input logic [TIME_W-1:0] a,
                                                        input logic [PER_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + (TIME_W + 1)'(b);
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    function automatic bit earlier(input int a, input int b);
        if (deadline_q[a] != deadline_q[b]) return deadline_q[a] < deadline_q[b];
        return a < b;
    endfunction

    function automatic t_result blank_result();
        t_result r;
        r = '0;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic queue_result(input t_result r);
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic predict_operation(input logic [95:0] d);
        logic [2:0]        mode;
        logic [TIME_W-1:0] now;
        logic [3:0]        slot;
        logic [PER_W-1:0]  per;
        logic              rep;
        logic              fnow;
        logic [TIME_W-1:0] start;
        t_result           r;
        int                s;
        int                best;
        int                n;
        bit                front;
        bit                any;
        bit                roll;
        bit                due [TIMER_SLOTS];
        int                order [16];
        mode = d[2:0];
        now  = d[50:3];
        slot = d[54:51];
        per  = d[86:55];
        rep  = d[87];
        fnow = d[88];
        r = blank_result();
        case (mode)
            MODE_ADD: begin
                s = -1;
                for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
                    if (!active_q[i]) s = i;
                end
                if (s < 0) begin
                    r.status = ST_FULL;
                end else begin
                    deadline_q[s] = add_saturate(now, per);
                    period_q[s] = per;
                    recurring_q[s] = rep;
                    active_q[s] = 1'b1;
                    front = !notice_q;
                    for (int i = 0; i < TIMER_SLOTS; i++) begin
                        if (i != s && active_q[i] && earlier(i, s)) front = 0;
                    end
                    if (front) notice_q = 1'b1;
                    r.status = ST_OK;
                    r.slot_out = 4'(s);
                    r.front_notice = front;
                end
                queue_result(r);
            end
            MODE_CANCEL, MODE_REFRESH, MODE_RESET: begin
                r.status = ST_NOP;
                if (slot < TIMER_SLOTS && active_q[slot]) begin
                    if (mode == MODE_CANCEL) begin
                        active_q[slot] = 1'b0;
                        r.status = ST_OK;
                    end else if (mode == MODE_REFRESH) begin
                        deadline_q[slot] = add_saturate(now, period_q[slot]);
                        r.status = ST_OK;
                    end else if (!(per == period_q[slot] && !fnow)) begin
                        if (fnow) start = now;
                        else if (deadline_q[slot] >= TIME_W'(period_q[slot]))
                            start = deadline_q[slot] - TIME_W'(period_q[slot]);
                        else start = '0;
                        period_q[slot] = per;
                        deadline_q[slot] = add_saturate(start, per);
                        r.status = ST_OK;
                    end
                end
                queue_result(r);
            end
            MODE_QUERY: begin
                notice_q = 1'b0;
                best = -1;
                for (int i = 0; i < TIMER_SLOTS; i++) begin
                    if (active_q[i] && (best < 0 || earlier(i, best))) best = i;
                end
                if (best < 0) begin
                    r.wait_ms = TIME_MAX;
                    r.none_pending = 1'b1;
                end else begin
                    r.wait_ms = (now >= deadline_q[best]) ? '0 : deadline_q[best] - now;
                end
                queue_result(r);
            end
            MODE_EXPIRE: begin
                any = 0;
                for (int i = 0; i < TIMER_SLOTS; i++) begin
                    if (active_q[i]) any = 1;
                end
                if (!any) begin
                    queue_result(r);
                end else begin
                    roll = (now < prev_time_q) && (prev_time_q >= TIME_W'(window_q))
                        && (now < prev_time_q - TIME_W'(window_q));
                    prev_time_q = now;
                    for (int i = 0; i < TIMER_SLOTS; i++) begin
                        due[i] = active_q[i] && (roll || deadline_q[i] <= now);
                    end
                    n = 0;
                    while (n < 16) begin
                        best = -1;
                        for (int i = 0; i < TIMER_SLOTS; i++) begin
                            if (due[i] && (best < 0 || earlier(i, best))) best = i;
                        end
                        if (best < 0) break;
                        due[best] = 0;
                        order[n] = best;
                        n++;
                    end
                    if (n == 0) begin
                        r.rolled_back = roll;
                        queue_result(r);
                    end
                    for (int k = 0; k < n; k++) begin
                        s = order[k];
                        if (recurring_q[s]) deadline_q[s] = add_saturate(now, period_q[s]);
                        else active_q[s] = 1'b0;
                        r = blank_result();
                        r.slot_out = 4'(s);
                        r.fired = 1'b1;
                        r.rolled_back = roll;
                        r.last = (k == n - 1);
                        queue_result(r);
                    end
                end
            end
            default: begin
                r.status = ST_NOP;
                queue_result(r);
            end
        endcase
    endtask

    task automatic compare_result(input logic [63:0] d, input logic lst);
        t_result got;
        t_result exp_r;
        got = '0;
        got.status = d[1:0];
        got.slot_out = d[5:2];
        got.fired = d[6];
        got.wait_ms = d[54:7];
        got.none_pending = d[55];
        got.front_notice = d[56];
        got.rolled_back = d[57];
        got.last = lst;
        if (expected_results.size() == 0) begin
            o_errors++;
            if (o_errors <= 10) $display("Unexpected result transaction: %p", got);
        end else begin
            exp_r = expected_results.pop_front();
            if (got !== exp_r || d[63:58] !== '0) begin
                o_errors++;
                if (o_errors <= 10)
                    $display("Result mismatch: expected %p, actual %p", exp_r, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TIMER_SLOTS; i++) begin
                deadline_q[i] = '0;
                period_q[i] = '0;
                recurring_q[i] = 1'b0;
                active_q[i] = 1'b0;
            end
            notice_q = 1'b0;
            prev_time_q = '0;
            window_q = WINDOW_RESET;
            expected_results.delete();
        end else begin
            if (i_rollback_we) window_q = i_rollback_wdata;
            if (i_m_tvalid && i_m_tready) begin
                compare_result(i_m_tdata, i_m_tlast);
                o_results++;
            end
            if (i_s_tvalid && i_s_tready) predict_operation(i_s_tdata);
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import tdt_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [2:0] MODE_UNDEF_LO = 3'd6;
    localparam logic [2:0] MODE_UNDEF_HI = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_rollback_we = 1'b0;
    logic [31:0] i_rollback_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;
    int          error_count;
    int          pending_count;
    int          result_count;
    int          cycle_count = 0;
    int          op_count = 0;
    int          stall_left = 0;
    bit          quiet = 0;
    logic [TIME_W-1:0] clock_ms = '0;

    timer_deadline_table_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rollback_we    (i_rollback_we),
        .i_rollback_wdata (i_rollback_wdata),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tlast     (m_axis_tlast)
    );

    timer_table_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rollback_we    (i_rollback_we),
        .i_rollback_wdata (i_rollback_wdata),
        .i_s_tvalid       (s_axis_tvalid),
        .i_s_tready       (s_axis_tready),
        .i_s_tdata        (s_axis_tdata),
        .i_m_tvalid       (m_axis_tvalid),
        .i_m_tready       (m_axis_tready),
        .i_m_tdata        (m_axis_tdata),
        .i_m_tlast        (m_axis_tlast),
        .o_errors         (error_count),
        .o_pending        (pending_count),
        .o_results        (result_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_operation(input logic [2:0] mode, input logic [TIME_W-1:0] now,
                                  input logic [3:0] slot, input logic [PER_W-1:0] per,
                                  input logic rep, input logic fnow);
        int gap;
        s_axis_tdata <= {7'd0, fnow, rep, per, slot, now, mode};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        op_count++;
        gap = (!quiet && $urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_window(input logic [31:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_rollback_we <= 1'b1;
        i_rollback_wdata <= value;
        @(posedge i_clk);
        i_rollback_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_operation();
        int pick;
        logic [2:0] mode;
        logic [PER_W-1:0] per;
        pick = $urandom_range(0, 99);
        if (pick < 25) mode = MODE_ADD;
        else if (pick < 50) mode = MODE_EXPIRE;
        else if (pick < 62) mode = MODE_QUERY;
        else if (pick < 72) mode = MODE_CANCEL;
        else if (pick < 82) mode = MODE_REFRESH;
        else if (pick < 95) mode = MODE_RESET;
        else mode = 3'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI));
        pick = $urandom_range(0, 99);
        if (pick < 4) clock_ms = TIME_W'({$urandom, $urandom});
        else if (pick < 9) clock_ms = clock_ms - TIME_W'($urandom_range(0, 20000));
        else clock_ms = clock_ms + TIME_W'($urandom_range(0, 60));
        per = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 200);
        send_operation(mode, clock_ms, 4'($urandom), per, 1'($urandom), 1'($urandom));
    endtask

    initial begin
        logic [31:0] windows [4];
        windows[0] = 32'd0;
        windows[1] = 32'hFFFF_FFFF;
        windows[2] = 32'd500;
        windows[3] = $urandom_range(1000, 100000);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_operation(MODE_QUERY, '0, 4'd0, '0, 1'b0, 1'b0);
        send_operation(MODE_EXPIRE, 48'd100, 4'd0, '0, 1'b0, 1'b0);
        send_operation(MODE_CANCEL, 48'd100, 4'd15, '0, 1'b0, 1'b0);
        send_operation(MODE_UNDEF_LO, TIME_MAX, 4'd15, '1, 1'b1, 1'b1);
        send_operation(MODE_UNDEF_HI, '0, 4'd0, '0, 1'b0, 1'b0);
        send_operation(MODE_ADD, TIME_MAX - 48'd5, 4'd0, '1, 1'b1, 1'b0);
        send_operation(MODE_ADD, 48'd1000, 4'd0, 32'd0, 1'b0, 1'b0);
        send_operation(MODE_ADD, 48'd1000, 4'd0, 32'd50, 1'b1, 1'b0);
        send_operation(MODE_QUERY, 48'd1010, 4'd0, '0, 1'b0, 1'b0);
        send_operation(MODE_RESET, 48'd1010, 4'd2, 32'd50, 1'b0, 1'b0);
        send_operation(MODE_RESET, 48'd1010, 4'd2, 32'd80, 1'b0, 1'b0);
        send_operation(MODE_RESET, 48'd1020, 4'd2, 32'd30, 1'b1, 1'b1);
        send_operation(MODE_RESET, 48'd1020, 4'd0, 32'd7, 1'b0, 1'b0);
        send_operation(MODE_REFRESH, 48'd1030, 4'd1, '0, 1'b0, 1'b0);
        send_operation(MODE_EXPIRE, 48'd1060, 4'd0, '0, 1'b0, 1'b0);
        send_operation(MODE_EXPIRE, 48'd1061, 4'd0, '0, 1'b0, 1'b0);
        for (int i = 0; i < 16; i++) begin
            send_operation(MODE_ADD, 48'd2000, 4'd0, 32'(i % 3), 1'(i), 1'b0);
        end
        send_operation(MODE_EXPIRE, 48'd5, 4'd0, '0, 1'b0, 1'b0);
        send_operation(MODE_EXPIRE, 48'd3000, 4'd0, '0, 1'b0, 1'b0);
        clock_ms = 48'd3000;

        for (int phase = 0; phase < 5; phase++) begin
            if (phase > 0) write_window(windows[phase - 1]);
            if (phase == 4) quiet = 1;
            repeat (62) random_operation();
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Summary: %0d operations and %0d result transactions over five window",
                 op_count, result_count);
        $display("settings, including zero and all ones, with clock jumps and a full table.");
        if (error_count == 0 && pending_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
